/* src/c2c_pkg.sv */
// Package for the coordinate-to-compressed-row converter.
// Holds the sequencer state type and field widths; no dependencies.
`default_nettype none
package c2c_pkg;
  localparam int RowW = 6;
  localparam int ColInW = 21;
  localparam int ColW = 20;
  localparam int ValW = 32;
  localparam int PtrW = 7;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_CLEAR
  } state_t;
endpackage
`default_nettype wire

/* src/c2c_if.sv */
// Valid/ready channel interfaces for the converter.
// Depends on c2c_pkg for field widths.
`default_nettype none
interface c2c_in_if;
  import c2c_pkg::*;
  logic              valid;
  logic              ready;
  logic [RowW-1:0]   row_index;
  logic [ColInW-1:0] col_index;
  logic [ValW-1:0]   entry_value;
  logic              final_entry;
  modport source (output valid, row_index, col_index, entry_value, final_entry, input ready);
  modport sink (input valid, row_index, col_index, entry_value, final_entry, output ready);
endinterface

interface c2c_out_if;
  import c2c_pkg::*;
  logic            valid;
  logic            ready;
  logic [RowW-1:0] out_row;
  logic [ColW-1:0] out_col;
  logic [ValW-1:0] out_value;
  logic            entry_valid;
  logic [PtrW-1:0] row_pointer;
  logic            pointer_valid;
  logic            dropped_flag;
  logic            last_result;
  modport source (output valid, out_row, out_col, out_value, entry_valid, row_pointer,
                  pointer_valid, dropped_flag, last_result, input ready);
  modport sink (input valid, out_row, out_col, out_value, entry_valid, row_pointer,
                pointer_valid, dropped_flag, last_result, output ready);
endinterface
`default_nettype wire

/* src/coo_to_csr_converter_core.sv */
// Top level of the coordinate-to-compressed-row converter.
// Depends on c2c_pkg and the channel interfaces in c2c_if.sv.
//
// Channel | Dir | Payload
// in      | in  | row_index, col_index, entry_value, final_entry
// out     | out | out_row, out_col, out_value, entry_valid, row_pointer,
//         |     | pointer_valid, dropped_flag, last_result
// cfg     | in  | cfg_wr_en, cfg_wr_data (row_count)
//
// An entry is sorted in by insertion: one shared compare unit walks the
// held entries from the top down, moving one memory word per cycle. A good
// entry is taken in, walked past each held entry that sorts after it, then
// placed; a dropped entry is only flagged. After the final entry, each
// result is read from memory and then loaded into the output register, where
// it is held while the sink stalls. The per-row counts sit in a small memory
// that is zeroed as results go out; rows above the last result that were
// touched are zeroed by a short pass right after it. Reset is synchronous,
// clears the held-entry count and the drop flag at once, and then runs a pass
// that zeroes every per-row count with input held off.
`default_nettype none
module coo_to_csr_converter_core #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_ROWS    = 63
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [c2c_pkg::RowW-1:0] cfg_wr_data,
  c2c_in_if.sink                    in_ch,
  c2c_out_if.source                 out_ch
);
  import c2c_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int NW = (CW > RowW + 1) ? CW : RowW + 1;
  localparam int WW = RowW + ColW + ValW;

  state_t state_r, state_nxt;

  logic [RowW-1:0] row_count_r;
  logic [WW-1:0]   mem [MAX_ENTRIES];
  logic [WW-1:0]   rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [WW-1:0]   wr_data;

  // Per-row entry counts, one word per row.
  logic [PtrW-1:0] cnt_mem [64];
  logic [PtrW-1:0] cnt_rd_r;
  logic [RowW-1:0] cnt_rd_addr;
  logic            cnt_wr_en;
  logic [RowW-1:0] cnt_wr_addr;
  logic [PtrW-1:0] cnt_wr_data;
  logic [RowW-1:0] clr_r, clr_nxt;       // count clearing address
  logic [RowW-1:0] dirty_r, dirty_nxt;   // highest count row touched

  logic [CW-1:0]   held_r, held_nxt;
  logic            drop_r, drop_nxt;
  logic            fin_r, fin_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;       // insertion walk position
  logic [WW-1:0]   new_r, new_nxt;       // entry being inserted
  logic [NW-1:0]   idx_r, idx_nxt;       // emit index
  logic [NW-1:0]   nres_r, nres_nxt;
  logic [PtrW-1:0] ptr_r, ptr_nxt;
  logic [RowW-1:0] rows_r, rows_nxt;

  // Output register.
  logic            ov_r;
  logic [RowW-1:0] orow_r;
  logic [ColW-1:0] ocol_r;
  logic [ValW-1:0] oval_r;
  logic            oev_r, opv_r, odrop_r, olast_r;
  logic [PtrW-1:0] optr_r;
  logic            out_load;

  logic [RowW-1:0] eff_rows;
  logic            bad;
  logic            moves;
  logic [RowW-1:0] in_row0;
  logic [ColW-1:0] in_col0;
  logic [NW-1:0]   held_ext, rows1;

  assign eff_rows = (row_count_r < RowW'(MAX_ROWS)) ? row_count_r : RowW'(MAX_ROWS);
  assign in_row0  = in_ch.row_index - RowW'(1);
  assign in_col0  = ColW'(in_ch.col_index - ColInW'(1));
  assign bad = (in_ch.row_index == '0) || (in_ch.row_index > eff_rows) ||
               (held_r >= CW'(MAX_ENTRIES));
  // Shared compare: does the stored word sort after the new one?
  assign moves = (rd_data_r[WW-1 -: RowW] > new_r[WW-1 -: RowW]) ||
                 ((rd_data_r[WW-1 -: RowW] == new_r[WW-1 -: RowW]) &&
                  (rd_data_r[ValW +: ColW] > new_r[ValW +: ColW]));
  assign held_ext = NW'(held_r);
  assign rows1    = NW'(eff_rows) + NW'(1);
  assign in_ch.ready = (state_r == ST_LOAD);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_ch.valid) begin
          if (!bad && held_r != '0) state_nxt = ST_SHIFT;
          else if (!bad) state_nxt = ST_PLACE;
          else if (in_ch.final_entry) state_nxt = ST_EMIT_RD;
        end
      end
      ST_SHIFT: begin
        if (!moves || pos_r == CW'(1)) state_nxt = ST_PLACE;
      end
      ST_PLACE:    state_nxt = fin_r ? ST_EMIT_RD : ST_LOAD;
      ST_EMIT_RD:  state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (!ov_r || out_ch.ready) begin
          if (idx_r + NW'(1) == nres_r)
            state_nxt = (dirty_r > idx_r[RowW-1:0]) ? ST_CLEAR : ST_LOAD;
          else
            state_nxt = ST_EMIT_RD;
        end
      end
      ST_CLEAR: begin
        if (clr_r == dirty_r) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Datapath controls.
  always_comb begin
    held_nxt = held_r; drop_nxt = drop_r; fin_nxt = fin_r; pos_nxt = pos_r;
    new_nxt = new_r; idx_nxt = idx_r; nres_nxt = nres_r; ptr_nxt = ptr_r;
    rows_nxt = rows_r; clr_nxt = clr_r; dirty_nxt = dirty_r;
    wr_en = 1'b0; wr_addr = AW'(pos_r); wr_data = new_r;
    rd_addr = AW'(pos_r - CW'(1));
    cnt_rd_addr = new_r[WW-1 -: RowW];
    cnt_wr_en = 1'b0; cnt_wr_addr = new_r[WW-1 -: RowW];
    cnt_wr_data = cnt_rd_r + PtrW'(1);
    out_load = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        rows_nxt = eff_rows;
        nres_nxt = (held_ext + NW'(!bad) > rows1) ? held_ext + NW'(!bad) : rows1;
        idx_nxt  = '0;
        ptr_nxt  = '0;
        rd_addr  = AW'(held_r - CW'(1));
        // Fetch the count of the arriving row for the increment at placement.
        cnt_rd_addr = in_row0;
        if (in_ch.valid) begin
          fin_nxt = in_ch.final_entry;
          new_nxt = {in_row0, in_col0, in_ch.entry_value};
          pos_nxt = held_r;
          if (bad) drop_nxt = 1'b1;
        end
      end
      ST_SHIFT: begin
        rd_addr = AW'(pos_r - CW'(2));
        if (moves) begin
          wr_en   = 1'b1;
          wr_data = rd_data_r;
          pos_nxt = pos_r - CW'(1);
        end
      end
      ST_PLACE: begin
        wr_en     = 1'b1;
        held_nxt  = held_r + CW'(1);
        cnt_wr_en = 1'b1;
        if (new_r[WW-1 -: RowW] > dirty_r) dirty_nxt = new_r[WW-1 -: RowW];
      end
      ST_EMIT_RD: begin
        rd_addr     = AW'(idx_r);
        cnt_rd_addr = idx_r[RowW-1:0];
      end
      ST_EMIT_OUT: begin
        rd_addr     = AW'(idx_r);
        cnt_rd_addr = idx_r[RowW-1:0];
        if (!ov_r || out_ch.ready) begin
          out_load = 1'b1;
          idx_nxt  = idx_r + NW'(1);
          // The count is consumed here, so its word is zeroed for the next set.
          cnt_wr_en   = 1'b1;
          cnt_wr_addr = idx_r[RowW-1:0];
          cnt_wr_data = '0;
          if (idx_r < NW'(rows_r))
            ptr_nxt = ptr_r + cnt_rd_r;
          if (idx_r + NW'(1) == nres_r) begin
            held_nxt = '0; drop_nxt = 1'b0;
            clr_nxt  = idx_r[RowW-1:0] + RowW'(1);
            if (dirty_r <= idx_r[RowW-1:0]) dirty_nxt = '0;
          end
        end
      end
      ST_CLEAR: begin
        cnt_wr_en   = 1'b1;
        cnt_wr_addr = clr_r;
        cnt_wr_data = '0;
        if (clr_r == dirty_r) dirty_nxt = '0;
        else clr_nxt = clr_r + RowW'(1);
      end
      default: ;
    endcase
  end

  // SHIFT needs the word below pos registered; a read each cycle covers it
  // since the walk steps the read address down by one each cycle.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_wr_en) cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    cnt_rd_r <= cnt_mem[cnt_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; held_r <= '0; drop_r <= 1'b0; ov_r <= 1'b0;
      row_count_r <= RowW'(1);
      clr_r <= '0; dirty_r <= '1;
    end else begin
      state_r <= state_nxt; held_r <= held_nxt; drop_r <= drop_nxt;
      clr_r <= clr_nxt; dirty_r <= dirty_nxt;
      if (cfg_wr_en) row_count_r <= cfg_wr_data;
      if (out_load) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt; pos_r <= pos_nxt; new_r <= new_nxt; idx_r <= idx_nxt;
    nres_r <= nres_nxt; ptr_r <= ptr_nxt; rows_r <= rows_nxt;
    if (out_load) begin
      oev_r   <= (idx_r < NW'(held_r));
      orow_r  <= (idx_r < NW'(held_r)) ? rd_data_r[WW-1 -: RowW] : '0;
      ocol_r  <= (idx_r < NW'(held_r)) ? rd_data_r[ValW +: ColW] : '0;
      oval_r  <= (idx_r < NW'(held_r)) ? rd_data_r[ValW-1:0] : '0;
      opv_r   <= (idx_r <= NW'(rows_r));
      optr_r  <= (idx_r <= NW'(rows_r)) ? ptr_r : '0;
      odrop_r <= drop_r;
      olast_r <= (idx_r + NW'(1) == nres_r);
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.out_row       = orow_r;
  assign out_ch.out_col       = ocol_r;
  assign out_ch.out_value     = oval_r;
  assign out_ch.entry_valid   = oev_r;
  assign out_ch.row_pointer   = optr_r;
  assign out_ch.pointer_valid = opv_r;
  assign out_ch.dropped_flag  = odrop_r;
  assign out_ch.last_result   = olast_r;

`ifndef ASSERT_OFF
  a_held_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(MAX_ENTRIES)) else $error("held count above capacity");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> !in_ch.ready) else $error("ready while busy");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && olast_r == 1'b0 && idx_r + NW'(1) == nres_r) |=> (held_r == '0))
    else $error("set not cleared after last result");
`endif
endmodule
`default_nettype wire
